>>> src/lpbc_pkg.sv
// ----------------------------------------------------------------------------
// lpbc_pkg
// Constants and types shared by the LCG pattern byte checker.
// ----------------------------------------------------------------------------
package lpbc_pkg;

  localparam int unsigned GEN_W   = 31;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 32;

  localparam logic [GEN_W-1:0]   LCG_MUL    = 31'h41C64E6D;
  localparam logic [GEN_W-1:0]   LCG_ADD    = 31'd12345;
  localparam logic [GEN_W-1:0]   SEED_RESET = 31'h1234567;
  localparam logic [BYTE_W-1:0]  ZERO_SUBST = 8'h5A;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;

  // Results of one check step
  typedef struct packed {
    logic [BYTE_W-1:0]  expected_byte;
    logic               mismatch;
    logic [COUNT_W-1:0] bad_count;
    logic [COUNT_W-1:0] byte_count;
  } lpbc_res_t;

endpackage

>>> src/lpbc_step.sv
// ----------------------------------------------------------------------------
// lpbc_step
// One generator step and compare: advances the LCG, derives the expected
// byte, flags a mismatch and bumps the saturating counters.
// ----------------------------------------------------------------------------
module lpbc_step
  import lpbc_pkg::*;
(
  input  logic [GEN_W-1:0]   seed,
  input  logic [GEN_W-1:0]   gen,
  input  logic [COUNT_W-1:0] bad_total,
  input  logic [COUNT_W-1:0] byte_total,
  input  logic [BYTE_W-1:0]  data_byte,
  input  logic               first,
  output logic [GEN_W-1:0]   gen_nxt,
  output lpbc_res_t          res
);

  logic [GEN_W-1:0]   gen_base;
  logic [GEN_W-1:0]   prod;
  logic [BYTE_W-1:0]  raw_byte;
  logic [COUNT_W-1:0] bad_base;
  logic [COUNT_W-1:0] byte_base;

  // Restart from seed with cleared counters on the first beat of a stream
  assign gen_base  = first ? seed : gen;
  assign bad_base  = first ? '0 : bad_total;
  assign byte_base = first ? '0 : byte_total;

  // Advance the generator; only the low 31 bits of the product matter
  assign prod    = gen_base * LCG_MUL;
  assign gen_nxt = prod + LCG_ADD;

  // Pick bits 23:16, substitute the fixed pattern for a zero byte
  assign raw_byte = gen_nxt[23:16];

  always_comb begin
    res.expected_byte = (raw_byte == '0) ? ZERO_SUBST : raw_byte;
    res.mismatch      = (data_byte != res.expected_byte);
    res.byte_count    = (byte_base == COUNT_MAX) ? byte_base : byte_base + COUNT_W'(1);
    if (res.mismatch && (bad_base != COUNT_MAX)) begin
      res.bad_count = bad_base + COUNT_W'(1);
    end else begin
      res.bad_count = bad_base;
    end
  end

endmodule

>>> src/lcg_pattern_byte_checker.sv
// An accepted beat waits in the input register until the output slot is free.
// Throughput: one beat per cycle while out_stall is low; the generator
// multiply-add is combinational around the generator register.
// Reset: synchronous, active low; seed and generator load 0x1234567,
// both counters clear, the pipeline empties.
// ----------------------------------------------------------------------------
// lcg_pattern_byte_checker
// Compares a byte stream against a 31-bit LCG pattern and keeps running
// byte and mismatch counts. Input register, one compute step, output register.
// ----------------------------------------------------------------------------
module lcg_pattern_byte_checker
  import lpbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [GEN_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_data_byte,
  input  logic               in_first,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BYTE_W-1:0]  out_expected_byte,
  output logic               out_mismatch,
  output logic [COUNT_W-1:0] out_bad_count,
  output logic [COUNT_W-1:0] out_byte_count
);

  logic [GEN_W-1:0]   seed_r;
  logic [GEN_W-1:0]   gen_r;
  logic [GEN_W-1:0]   gen_nxt;
  logic [COUNT_W-1:0] bad_total_r;
  logic [COUNT_W-1:0] byte_total_r;
  logic               s1_valid_r;
  logic [BYTE_W-1:0]  s1_data_r;
  logic               s1_first_r;
  logic               out_valid_r;
  lpbc_res_t          res;
  lpbc_res_t          res_r;
  logic               out_free;
  logic               s1_adv;
  logic               in_take;

  // Pipeline advance: output slot free, input register moves on
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Hold the seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r  <= in_data_byte;
      s1_first_r <= in_first;
    end
  end

  lpbc_step u_step (
    .seed       (seed_r),
    .gen        (gen_r),
    .bad_total  (bad_total_r),
    .byte_total (byte_total_r),
    .data_byte  (s1_data_r),
    .first      (s1_first_r),
    .gen_nxt    (gen_nxt),
    .res        (res)
  );

  // Advance generator and counters as a beat moves to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r        <= SEED_RESET;
      bad_total_r  <= '0;
      byte_total_r <= '0;
    end else if (s1_adv) begin
      gen_r        <= gen_nxt;
      bad_total_r  <= res.bad_count;
      byte_total_r <= res.byte_count;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_expected_byte = res_r.expected_byte;
  assign out_mismatch      = res_r.mismatch;
  assign out_bad_count     = res_r.bad_count;
  assign out_byte_count    = res_r.byte_count;

endmodule
